[hdl/workgroup_size_splitter_top_assert.svh]
// Assertion macros for the workgroup size splitter
`ifndef WORKGROUP_SIZE_SPLITTER_TOP_ASSERT_SVH
`define WORKGROUP_SIZE_SPLITTER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define WSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define WSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/wss_pkg.sv]
`timescale 1ns / 1ps
package wss_pkg;

    // Field widths and limit register
    localparam int DIM_W_DEF = 16;
    localparam int LIMIT_W   = 20;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1536);

    // Microcode field widths
    localparam int STEP_W = 4;
    localparam int OP_W   = 4;
    localparam int CND_W  = 4;

    // Datapath operations
    localparam logic [OP_W-1:0] OP_NOP   = 4'd0;
    localparam logic [OP_W-1:0] OP_MUL01 = 4'd1;  // product of groups x and y
    localparam logic [OP_W-1:0] OP_MUL2  = 4'd2;  // times group z
    localparam logic [OP_W-1:0] OP_SEL   = 4'd3;  // pick largest dim, divisor 2
    localparam logic [OP_W-1:0] OP_DLOAD = 4'd4;  // start a trial division
    localparam logic [OP_W-1:0] OP_DSTEP = 4'd5;  // one quotient bit
    localparam logic [OP_W-1:0] OP_TAKE  = 4'd6;  // factor is trial divisor
    localparam logic [OP_W-1:0] OP_PRIME = 4'd7;  // factor is the dim itself
    localparam logic [OP_W-1:0] OP_DINC  = 4'd8;  // next trial divisor
    localparam logic [OP_W-1:0] OP_APPLY = 4'd9;  // new group, count times factor
    localparam logic [OP_W-1:0] OP_CWR   = 4'd10; // write back count
    localparam logic [OP_W-1:0] OP_DONE  = 4'd11; // result strobe

    // Jump conditions
    localparam logic [CND_W-1:0] CND_NEVER  = 4'd0;
    localparam logic [CND_W-1:0] CND_ALWAYS = 4'd1;
    localparam logic [CND_W-1:0] CND_NSTART = 4'd2;
    localparam logic [CND_W-1:0] CND_ZERO   = 4'd3;
    localparam logic [CND_W-1:0] CND_GT     = 4'd4;
    localparam logic [CND_W-1:0] CND_LE     = 4'd5;
    localparam logic [CND_W-1:0] CND_BIGLT2 = 4'd6;
    localparam logic [CND_W-1:0] CND_DMORE  = 4'd7;
    localparam logic [CND_W-1:0] CND_REMZ   = 4'd8;
    localparam logic [CND_W-1:0] CND_QGED   = 4'd9;

    // Program steps
    localparam logic [STEP_W-1:0] ST_IDLE  = 4'd0;
    localparam logic [STEP_W-1:0] ST_MUL01 = 4'd1;
    localparam logic [STEP_W-1:0] ST_CMP1  = 4'd2;
    localparam logic [STEP_W-1:0] ST_MUL2  = 4'd3;
    localparam logic [STEP_W-1:0] ST_CMP2  = 4'd4;
    localparam logic [STEP_W-1:0] ST_SEL   = 4'd5;
    localparam logic [STEP_W-1:0] ST_DLOAD = 4'd6;
    localparam logic [STEP_W-1:0] ST_DSTEP = 4'd7;
    localparam logic [STEP_W-1:0] ST_TESTR = 4'd8;
    localparam logic [STEP_W-1:0] ST_TESTQ = 4'd9;
    localparam logic [STEP_W-1:0] ST_PRIME = 4'd10;
    localparam logic [STEP_W-1:0] ST_APPLY = 4'd11;
    localparam logic [STEP_W-1:0] ST_CWR   = 4'd12;
    localparam logic [STEP_W-1:0] ST_DONE  = 4'd13;
    localparam logic [STEP_W-1:0] ST_INC   = 4'd14;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CND_W-1:0]  cnd;
        logic [STEP_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic any_zero;
        logic gt;
        logic big_lt2;
        logic div_more;
        logic rem_zero;
        logic q_ge_d;
    } t_status;

    // Control store: falls through to the next step unless the jump is taken
    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        unique case (step)
            ST_IDLE:  w = '{OP_NOP,   CND_NSTART, ST_IDLE};
            ST_MUL01: w = '{OP_MUL01, CND_ZERO,   ST_DONE};
            ST_CMP1:  w = '{OP_NOP,   CND_GT,     ST_SEL};
            ST_MUL2:  w = '{OP_MUL2,  CND_NEVER,  ST_IDLE};
            ST_CMP2:  w = '{OP_NOP,   CND_LE,     ST_DONE};
            ST_SEL:   w = '{OP_SEL,   CND_BIGLT2, ST_DONE};
            ST_DLOAD: w = '{OP_DLOAD, CND_NEVER,  ST_IDLE};
            ST_DSTEP: w = '{OP_DSTEP, CND_DMORE,  ST_DSTEP};
            ST_TESTR: w = '{OP_TAKE,  CND_REMZ,   ST_APPLY};
            ST_TESTQ: w = '{OP_NOP,   CND_QGED,   ST_INC};
            ST_PRIME: w = '{OP_PRIME, CND_NEVER,  ST_IDLE};
            ST_APPLY: w = '{OP_APPLY, CND_NEVER,  ST_IDLE};
            ST_CWR:   w = '{OP_CWR,   CND_ALWAYS, ST_MUL01};
            ST_DONE:  w = '{OP_DONE,  CND_ALWAYS, ST_IDLE};
            ST_INC:   w = '{OP_DINC,  CND_ALWAYS, ST_DLOAD};
            default:  w = '{OP_NOP,   CND_ALWAYS, ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

[hdl/workgroup_size_splitter_top.sv]
// Each limit check multiplies x by y and compares, then multiplies by z and compares (a zero dimension ends it early),
// then the result is strobed; each split adds a select step, a trial division per divisor and a step more for a prime.
// Throughput: one word at a time; the next word is taken the cycle after the result strobe.
// The trial division loop sets the run time: up to about 255 trials a split at 16 bits.
// Reset (synchronous, active low) returns the sequencer to idle and the limit to 1536.
// Results are strobed for one cycle; the receiver cannot stall.
`timescale 1ns / 1ps
`include "workgroup_size_splitter_top_assert.svh"
module workgroup_size_splitter_top #(
    parameter int DIM_WIDTH = wss_pkg::DIM_W_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [wss_pkg::LIMIT_W-1:0] i_cfg_data,
    input  logic                        start,
    output logic                        busy,
    input  logic [DIM_WIDTH-1:0]        i_work_x,
    input  logic [DIM_WIDTH-1:0]        i_work_y,
    input  logic [DIM_WIDTH-1:0]        i_work_z,
    output logic                        o_done,
    output logic [DIM_WIDTH-1:0]        o_group_x,
    output logic [DIM_WIDTH-1:0]        o_group_y,
    output logic [DIM_WIDTH-1:0]        o_group_z,
    output logic [DIM_WIDTH-1:0]        o_count_x,
    output logic [DIM_WIDTH-1:0]        o_count_y,
    output logic [DIM_WIDTH-1:0]        o_count_z
);
    import wss_pkg::*;

    logic [OP_W-1:0] op;
    t_status         status;
    logic            accept;

    // Word taken while idle
    assign accept = start && !busy;

    wss_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_op     (op),
        .o_busy   (busy),
        .o_done   (o_done)
    );

    wss_dp #(
        .DIM_WIDTH (DIM_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_op       (op),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_work_x   (i_work_x),
        .i_work_y   (i_work_y),
        .i_work_z   (i_work_z),
        .o_status   (status),
        .o_group_x  (o_group_x),
        .o_group_y  (o_group_y),
        .o_group_z  (o_group_z),
        .o_count_x  (o_count_x),
        .o_count_y  (o_count_y),
        .o_count_z  (o_count_z)
    );

    // Checks
    `WSS_ASSERT_NEXT(a_accept_busy, accept, busy, "not busy after accepting a word")
    `WSS_ASSERT_NOW(a_done_busy, o_done, busy, "result strobe while idle")
    `WSS_ASSERT_NEXT(a_done_idle, o_done, !busy && !o_done, "no return to idle after result")
    `WSS_ASSERT_NOW(a_count_nz, o_done,
        (o_count_x != '0) && (o_count_y != '0) && (o_count_z != '0), "zero workgroup count")

endmodule

[hdl/wss_seq.sv]
`timescale 1ns / 1ps
module wss_seq (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    input  wss_pkg::t_status               i_status,
    output logic [wss_pkg::OP_W-1:0]       o_op,
    output logic                           o_busy,
    output logic                           o_done
);
    import wss_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_uword            uw;
    logic              jump;

    assign uw = ucode(r_step);

    // Jump condition select
    always_comb begin
        unique case (uw.cnd)
            CND_NEVER:  jump = 1'b0;
            CND_ALWAYS: jump = 1'b1;
            CND_NSTART: jump = !start;
            CND_ZERO:   jump = i_status.any_zero;
            CND_GT:     jump = i_status.gt;
            CND_LE:     jump = !i_status.gt;
            CND_BIGLT2: jump = i_status.big_lt2;
            CND_DMORE:  jump = i_status.div_more;
            CND_REMZ:   jump = i_status.rem_zero;
            CND_QGED:   jump = i_status.q_ge_d;
            default:    jump = 1'b0;
        endcase
        n_step = jump ? uw.target : r_step + STEP_W'(1);
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_op   = uw.op;
    assign o_busy = (r_step != ST_IDLE);
    assign o_done = (uw.op == OP_DONE);

endmodule

[hdl/wss_div.sv]
`timescale 1ns / 1ps
module wss_div #(
    parameter int DIM_WIDTH = wss_pkg::DIM_W_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  logic                 i_step,
    input  logic [DIM_WIDTH-1:0] i_dividend,
    input  logic [DIM_WIDTH-1:0] i_divisor,
    output logic [DIM_WIDTH-1:0] o_quo,
    output logic [DIM_WIDTH-1:0] o_rem,
    output logic                 o_more
);
    import wss_pkg::*;

    localparam int CW = $clog2(DIM_WIDTH);

    logic [DIM_WIDTH-1:0] r_rem;
    logic [DIM_WIDTH-1:0] r_quo;
    logic [CW-1:0]        r_cnt;
    logic [DIM_WIDTH:0]   shifted;
    logic [DIM_WIDTH:0]   diff;
    logic                 fits;

    // Restoring division, one quotient bit a cycle while i_step is high
    assign shifted = {r_rem, r_quo[DIM_WIDTH-1]};
    assign diff    = shifted - {1'b0, i_divisor};
    assign fits    = !diff[DIM_WIDTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= CW'(DIM_WIDTH - 1);
        end else if (i_step) begin
            r_cnt <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (i_step) begin
            r_rem <= fits ? diff[DIM_WIDTH-1:0] : shifted[DIM_WIDTH-1:0];
            r_quo <= {r_quo[DIM_WIDTH-2:0], fits};
        end
    end

    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
    assign o_more = (r_cnt != '0);

endmodule

[hdl/wss_dp.sv]
`timescale 1ns / 1ps
module wss_dp #(
    parameter int DIM_WIDTH = wss_pkg::DIM_W_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [wss_pkg::OP_W-1:0]      i_op,
    input  logic                          i_cfg_we,
    input  logic [wss_pkg::LIMIT_W-1:0]   i_cfg_data,
    input  logic [DIM_WIDTH-1:0]          i_work_x,
    input  logic [DIM_WIDTH-1:0]          i_work_y,
    input  logic [DIM_WIDTH-1:0]          i_work_z,
    output wss_pkg::t_status              o_status,
    output logic [DIM_WIDTH-1:0]          o_group_x,
    output logic [DIM_WIDTH-1:0]          o_group_y,
    output logic [DIM_WIDTH-1:0]          o_group_z,
    output logic [DIM_WIDTH-1:0]          o_count_x,
    output logic [DIM_WIDTH-1:0]          o_count_y,
    output logic [DIM_WIDTH-1:0]          o_count_z
);
    import wss_pkg::*;

    localparam int MA = (DIM_WIDTH > LIMIT_W) ? DIM_WIDTH : LIMIT_W;
    localparam int PW = MA + DIM_WIDTH;

    logic [DIM_WIDTH-1:0] r_grp [3];
    logic [DIM_WIDTH-1:0] r_cnt [3];
    logic [1:0]           r_sel;
    logic [DIM_WIDTH-1:0] r_v;
    logic [DIM_WIDTH-1:0] r_d;
    logic [DIM_WIDTH-1:0] r_fac;
    logic [DIM_WIDTH-1:0] r_newg;
    logic [PW-1:0]        r_prod;
    logic [LIMIT_W-1:0]   r_limit;

    logic [MA-1:0]        mul_a;
    logic [DIM_WIDTH-1:0] mul_b;
    logic [1:0]           sel_c;
    logic [DIM_WIDTH-1:0] big_c;
    logic [DIM_WIDTH-1:0] div_quo;
    logic [DIM_WIDTH-1:0] div_rem;
    logic                 div_more;

    // Limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    // Shared multiplier operands
    always_comb begin
        unique case (i_op)
            OP_MUL01: begin
                mul_a = MA'(r_grp[0]);
                mul_b = r_grp[1];
            end
            OP_MUL2: begin
                mul_a = r_prod[MA-1:0];
                mul_b = r_grp[2];
            end
            default: begin
                mul_a = MA'(r_cnt[r_sel]);
                mul_b = r_fac;
            end
        endcase
    end

    // Largest group dimension, lowest index on ties
    always_comb begin
        sel_c = 2'd0;
        big_c = r_grp[0];
        if (r_grp[1] > big_c) begin
            sel_c = 2'd1;
            big_c = r_grp[1];
        end
        if (r_grp[2] > big_c) begin
            sel_c = 2'd2;
            big_c = r_grp[2];
        end
    end

    wss_div #(
        .DIM_WIDTH (DIM_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (i_op == OP_DLOAD),
        .i_step     (i_op == OP_DSTEP),
        .i_dividend (r_v),
        .i_divisor  (r_d),
        .o_quo      (div_quo),
        .o_rem      (div_rem),
        .o_more     (div_more)
    );

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_grp[0] <= i_work_x;
            r_grp[1] <= i_work_y;
            r_grp[2] <= i_work_z;
            r_cnt[0] <= DIM_WIDTH'(1);
            r_cnt[1] <= DIM_WIDTH'(1);
            r_cnt[2] <= DIM_WIDTH'(1);
        end else begin
            unique case (i_op)
                OP_MUL01, OP_MUL2, OP_APPLY: begin
                    r_prod <= PW'(mul_a * mul_b);
                    if (i_op == OP_APPLY) begin
                        r_grp[r_sel] <= r_newg;
                    end
                end
                OP_SEL: begin
                    r_sel <= sel_c;
                    r_v   <= big_c;
                    r_d   <= DIM_WIDTH'(2);
                end
                OP_TAKE: begin
                    r_fac  <= r_d;
                    r_newg <= div_quo;
                end
                OP_PRIME: begin
                    r_fac  <= r_v;
                    r_newg <= DIM_WIDTH'(1);
                end
                OP_DINC:  r_d <= r_d + DIM_WIDTH'(1);
                OP_CWR:   r_cnt[r_sel] <= r_prod[DIM_WIDTH-1:0];
                default:  ;
            endcase
        end
    end

    // Status to the sequencer
    assign o_status.any_zero = (r_grp[0] == '0) || (r_grp[1] == '0) || (r_grp[2] == '0);
    assign o_status.gt       = (r_prod > PW'(r_limit));
    assign o_status.big_lt2  = (big_c < DIM_WIDTH'(2));
    assign o_status.div_more = div_more;
    assign o_status.rem_zero = (div_rem == '0);
    assign o_status.q_ge_d   = (div_quo >= r_d);

    assign o_group_x = r_grp[0];
    assign o_group_y = r_grp[1];
    assign o_group_z = r_grp[2];
    assign o_count_x = r_cnt[0];
    assign o_count_y = r_cnt[1];
    assign o_count_z = r_cnt[2];

endmodule
